// ===== rtl/sntdl_pkg.sv =====
// Package for the short name to dotted lowercase converter.
// Holds character codes, widths and the job descriptor passed between stages.
// No dependencies.
package sntdl_pkg;

  localparam int unsigned POS_W   = 4;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SPACE_W = 3;
  localparam int unsigned TOTAL_W = 4;

  localparam logic [CHAR_W-1:0]  CH_NUL      = 8'h00;
  localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0]  CH_DOT      = 8'h2E;
  localparam logic [CHAR_W-1:0]  CH_UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0]  CH_UPPER_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0]  CASE_OFFSET = 8'h20;

  localparam logic [SPACE_W-1:0] SPACE_MAX   = 3'd7;
  localparam logic [SPACE_W-1:0] ROOM_FULL   = 3'd7;
  localparam logic [SPACE_W-1:0] ROOM_LAST   = 3'd6;
  localparam logic [TOTAL_W-1:0] MAX_RESULTS = 4'd8;

  typedef struct packed {
    logic [SPACE_W-1:0] spaces;
    logic               dot;
    logic               chr_v;
    logic [CHAR_W-1:0]  chr;
    logic               term;
  } job_t;

endpackage

// ===== rtl/sntdl_if.sv =====
// Handshake interfaces for the name byte channel and the output character channel.
// Depends on sntdl_pkg.
interface sntdl_name_if;
  logic                            valid;
  logic                            ready;
  logic [sntdl_pkg::CHAR_W-1:0]    name_byte;

  modport source(output valid, output name_byte, input ready);
  modport sink(input valid, input name_byte, output ready);
endinterface

interface sntdl_char_if;
  logic                            valid;
  logic                            ready;
  logic [sntdl_pkg::CHAR_W-1:0]    out_char;
  logic                            run_last;
  logic                            name_done;

  modport source(output valid, output out_char, output run_last, output name_done,
                 input ready);
  modport sink(input valid, input out_char, input run_last, input name_done,
               output ready);
endinterface

// ===== rtl/sntdl_front.sv =====
// Intake stage: tracks position, held spaces and dot state, builds a job per non-space byte and for the last byte.
// Depends on sntdl_pkg and sntdl_if.
module sntdl_front #(
  parameter int NAME_LEN = 11,
  parameter int BASE_LEN = 8
) (
  input  logic                clk,
  input  logic                rst,
  sntdl_name_if.sink          name_ch,
  input  logic                job_free,
  output logic                job_load,
  output sntdl_pkg::job_t     job
);

  logic [sntdl_pkg::POS_W-1:0]   byte_position, byte_position_next;
  logic [sntdl_pkg::SPACE_W-1:0] pending_spaces, pending_spaces_next;
  logic                          dot_emitted, dot_emitted_next;

  logic                          accept;
  logic                          is_space;
  logic                          last;
  logic                          in_base;
  logic [sntdl_pkg::SPACE_W-1:0] room;
  logic [sntdl_pkg::CHAR_W-1:0]  b;

  assign name_ch.ready = job_free;
  assign accept        = name_ch.valid && name_ch.ready;
  assign b             = name_ch.name_byte;
  assign is_space      = (b == sntdl_pkg::CH_SPACE);
  assign last          = ({1'b0, byte_position} + 5'd1) >= 5'(NAME_LEN);
  assign in_base       = byte_position < sntdl_pkg::POS_W'(BASE_LEN);
  assign room          = last ? sntdl_pkg::ROOM_LAST : sntdl_pkg::ROOM_FULL;
  assign job_load      = accept && (!is_space || last);

  always_comb begin
    job.spaces = '0;
    job.dot    = 1'b0;
    job.chr_v  = !is_space;
    job.chr    = b;
    job.term   = last;
    if (b >= sntdl_pkg::CH_UPPER_A && b <= sntdl_pkg::CH_UPPER_Z) begin
      job.chr = b + sntdl_pkg::CASE_OFFSET;
    end
    if (!is_space) begin
      if (in_base) begin
        job.spaces = (pending_spaces < room) ? pending_spaces : room;
      end else begin
        job.dot = !dot_emitted;
      end
    end
  end

  always_comb begin
    byte_position_next  = byte_position;
    pending_spaces_next = pending_spaces;
    dot_emitted_next    = dot_emitted;
    if (accept) begin
      if (is_space) begin
        if (in_base && pending_spaces != sntdl_pkg::SPACE_MAX) begin
          pending_spaces_next = pending_spaces + 3'd1;
        end
      end else if (in_base) begin
        pending_spaces_next = '0;
      end else begin
        dot_emitted_next = 1'b1;
      end
      if (last) begin
        byte_position_next  = '0;
        pending_spaces_next = '0;
        dot_emitted_next    = 1'b0;
      end else begin
        byte_position_next = byte_position + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      pending_spaces <= '0;
      dot_emitted    <= 1'b0;
    end else begin
      byte_position  <= byte_position_next;
      pending_spaces <= pending_spaces_next;
      dot_emitted    <= dot_emitted_next;
    end
  end

endmodule

// ===== rtl/sntdl_emit.sv =====
// Result sequencer: holds one job and moves its characters, one per cycle unless the output stalls,
// into the output register. Depends on sntdl_pkg and sntdl_if.
module sntdl_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_load,
  input  sntdl_pkg::job_t     job_in,
  output logic                job_free,
  sntdl_char_if.source        char_ch
);

  sntdl_pkg::job_t               job, job_next;
  logic                          job_valid, job_valid_next;
  logic                          out_valid;
  logic [sntdl_pkg::CHAR_W-1:0]  out_char;
  logic                          run_last;
  logic                          name_done;

  logic                          out_adv;
  logic                          step;
  logic                          final_word;
  logic [sntdl_pkg::TOTAL_W-1:0] total;
  logic [sntdl_pkg::CHAR_W-1:0]  cur_char;
  logic                          cur_done;

  assign char_ch.valid     = out_valid;
  assign char_ch.out_char  = out_char;
  assign char_ch.run_last  = run_last;
  assign char_ch.name_done = name_done;

  assign out_adv    = !out_valid || char_ch.ready;
  assign step       = job_valid && out_adv;
  assign total      = {1'b0, job.spaces} + {3'b000, job.dot} + {3'b000, job.chr_v}
                    + {3'b000, job.term};
  assign final_word = (total == 4'd1);
  assign job_free   = !job_valid || (out_adv && final_word);

  always_comb begin
    job_next = job;
    cur_done = 1'b0;
    if (job.spaces != '0) begin
      cur_char        = sntdl_pkg::CH_SPACE;
      job_next.spaces = job.spaces - 3'd1;
    end else if (job.dot) begin
      cur_char     = sntdl_pkg::CH_DOT;
      job_next.dot = 1'b0;
    end else if (job.chr_v) begin
      cur_char       = job.chr;
      job_next.chr_v = 1'b0;
    end else begin
      cur_char      = sntdl_pkg::CH_NUL;
      cur_done      = 1'b1;
      job_next.term = 1'b0;
    end
  end

  always_comb begin
    job_valid_next = job_valid;
    if (step && final_word) begin
      job_valid_next = 1'b0;
    end
    if (job_load) begin
      job_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      job_valid <= job_valid_next;
      if (out_adv) begin
        out_valid <= job_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end else if (step) begin
      job <= job_next;
    end
    if (step) begin
      out_char  <= cur_char;
      run_last  <= final_word;
      name_done <= cur_done;
    end
  end

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    job_load |-> job_free)
    else $error("job loaded while sequencer busy");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !out_adv) |=> ($stable(job) && job_valid))
    else $error("job changed while output stalled");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (total != '0 && total <= sntdl_pkg::MAX_RESULTS))
    else $error("job result count out of range");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && name_done) |-> (run_last && out_char == sntdl_pkg::CH_NUL))
    else $error("terminator not marked last");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (step && final_word && !job_load) |=> (!job_valid && out_valid && run_last))
    else $error("job did not drain after final word");
`endif

endmodule

// ===== rtl/short_name_to_dotted_lowercase.sv =====
// Top level of the 8.3 short name to dotted lowercase converter.
// Depends on sntdl_pkg, sntdl_if, sntdl_front and sntdl_emit.
//
//   channel   dir   payload                           handshake
//   name_ch   in    name_byte[7:0]                    valid/ready
//   char_ch   out   out_char[7:0] run_last name_done  valid/ready
//
// An item with results holds the sequencer until all of its results (1 to 8) are sent.
// A space with no terminator, in the base or the extension part, gives no result.
// Intake rate is set by the result sequencer; results pass through the output register.
// Synchronous reset clears position, held spaces, dot flag, job valid and output valid.
// A stall on char_ch holds the output register and the job; intake waits while a job is held.
module short_name_to_dotted_lowercase #(
  parameter int NAME_LEN = 11,
  parameter int BASE_LEN = 8
) (
  input  logic          clk,
  input  logic          rst,
  sntdl_name_if.sink    name_ch,
  sntdl_char_if.source  char_ch
);

  sntdl_pkg::job_t job;
  logic            job_load;
  logic            job_free;

  sntdl_front #(
    .NAME_LEN (NAME_LEN),
    .BASE_LEN (BASE_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .name_ch  (name_ch),
    .job_free (job_free),
    .job_load (job_load),
    .job      (job)
  );

  sntdl_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .job_load (job_load),
    .job_in   (job),
    .job_free (job_free),
    .char_ch  (char_ch)
  );

endmodule

// ===== bench/tb.sv =====
// Testbench for the 8.3 short name to dotted lowercase converter.
// Depends on sntdl_pkg, sntdl_if and short_name_to_dotted_lowercase.
// Drives directed and random name bytes and checks every output word against a predictor or the directed table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_LEN     = 11;
  localparam int BASE_LEN     = 8;
  localparam int DIRECTED_N   = 22;
  localparam int RANDOM_NAMES = 42;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_AT     = 150;
  localparam int STALL_CYCLES = 300;
  localparam int REPORT_MAX   = 10;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [sntdl_pkg::CHAR_W-1:0] out_char;
    logic                         run_last;
    logic                         name_done;
  } char_word_t;

  typedef struct packed {
    logic                         typed;
    logic [sntdl_pkg::CHAR_W-1:0] name_byte;
    logic [sntdl_pkg::CHAR_W-1:0] want;
  } row_t;

  logic clk;
  logic rst;

  sntdl_name_if name_ch ();
  sntdl_char_if char_ch ();

  short_name_to_dotted_lowercase #(
    .NAME_LEN(NAME_LEN),
    .BASE_LEN(BASE_LEN)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .name_ch(name_ch),
    .char_ch(char_ch)
  );

  row_t directed_rows [DIRECTED_N] = '{
    '{1'b1, 8'h41, 8'h61}, '{1'b1, 8'h00, 8'h00}, '{1'b0, 8'h20, 8'h00},
    '{1'b0, 8'h20, 8'h00}, '{1'b0, 8'hFF, 8'h00}, '{1'b1, 8'h5A, 8'h7A},
    '{1'b1, 8'h40, 8'h40}, '{1'b0, 8'h20, 8'h00}, '{1'b0, 8'h20, 8'h00},
    '{1'b0, 8'h5B, 8'h00}, '{1'b0, 8'h41, 8'h00},
    '{1'b0, 8'h20, 8'h00}, '{1'b0, 8'h20, 8'h00}, '{1'b0, 8'h20, 8'h00},
    '{1'b0, 8'h20, 8'h00}, '{1'b0, 8'h20, 8'h00}, '{1'b0, 8'h20, 8'h00},
    '{1'b0, 8'h20, 8'h00}, '{1'b0, 8'h20, 8'h00}, '{1'b0, 8'h58, 8'h00},
    '{1'b0, 8'h20, 8'h00}, '{1'b0, 8'h20, 8'h00}
  };

  logic [sntdl_pkg::POS_W-1:0]   name_pos;
  logic [sntdl_pkg::SPACE_W-1:0] held_spaces;
  logic                          dot_seen;
  char_word_t                    fresh_words [$];
  char_word_t                    dotted_chars [$];

  bit gaps_on;
  int bytes_in;
  int mismatches;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void convert_name_byte(input logic [sntdl_pkg::CHAR_W-1:0] raw);
    bit                            last;
    bit                            in_base;
    logic [sntdl_pkg::SPACE_W-1:0] room;
    logic [sntdl_pkg::SPACE_W-1:0] n;
    logic [sntdl_pkg::CHAR_W-1:0]  ch;
    last    = (int'(name_pos) + 1 >= NAME_LEN);
    in_base = (int'(name_pos) < BASE_LEN);
    fresh_words.delete();
    if (raw == sntdl_pkg::CH_SPACE) begin
      if (in_base && held_spaces < sntdl_pkg::SPACE_MAX) held_spaces++;
    end else begin
      if (in_base) begin
        room = last ? sntdl_pkg::ROOM_LAST : sntdl_pkg::ROOM_FULL;
        n = (held_spaces < room) ? held_spaces : room;
        repeat (n) fresh_words.push_back('{sntdl_pkg::CH_SPACE, 1'b0, 1'b0});
        held_spaces = '0;
      end else if (!dot_seen) begin
        fresh_words.push_back('{sntdl_pkg::CH_DOT, 1'b0, 1'b0});
        dot_seen = 1'b1;
      end
      ch = raw;
      if (raw >= sntdl_pkg::CH_UPPER_A && raw <= sntdl_pkg::CH_UPPER_Z)
        ch = raw + sntdl_pkg::CASE_OFFSET;
      fresh_words.push_back('{ch, 1'b0, 1'b0});
    end
    if (last) begin
      fresh_words.push_back('{sntdl_pkg::CH_NUL, 1'b0, 1'b1});
      name_pos    = '0;
      held_spaces = '0;
      dot_seen    = 1'b0;
    end else begin
      name_pos = name_pos + 1'b1;
    end
    if (fresh_words.size() > 0) fresh_words[fresh_words.size()-1].run_last = 1'b1;
  endfunction

  // Enter and leave at a falling edge.
  task automatic offer_byte(input logic [sntdl_pkg::CHAR_W-1:0] raw, input logic typed,
                            input logic [sntdl_pkg::CHAR_W-1:0] want);
    while (gaps_on && $urandom_range(99) < 12) begin
      name_ch.valid <= 1'b0;
      @(negedge clk);
    end
    name_ch.valid     <= 1'b1;
    name_ch.name_byte <= raw;
    do @(posedge clk); while (!name_ch.ready);
    convert_name_byte(raw);
    if (typed) begin
      dotted_chars.push_back('{want, 1'b1, 1'b0});
    end else begin
      foreach (fresh_words[i]) dotted_chars.push_back(fresh_words[i]);
    end
    bytes_in++;
    @(negedge clk);
  endtask

  function automatic logic [sntdl_pkg::CHAR_W-1:0] name_char();
    case ($urandom_range(3))
      0, 1:    return sntdl_pkg::CHAR_W'($urandom_range(sntdl_pkg::CH_UPPER_A,
                                                          sntdl_pkg::CH_UPPER_Z));
      2:       return sntdl_pkg::CHAR_W'($urandom_range(8'h30, 8'h39));
      default: return sntdl_pkg::CHAR_W'($urandom_range(255));
    endcase
  endfunction

  task automatic offer_random_name();
    int                           kind;
    int                           base_used;
    int                           ext_used;
    int                           lead;
    logic [sntdl_pkg::CHAR_W-1:0] raw;
    kind      = $urandom_range(9);
    base_used = $urandom_range(BASE_LEN);
    ext_used  = $urandom_range(NAME_LEN - BASE_LEN);
    lead      = $urandom_range(1, BASE_LEN - 1);
    for (int p = 0; p < NAME_LEN; p++) begin
      if (kind <= 4) begin
        if (p < BASE_LEN) raw = (p < base_used) ? name_char() : sntdl_pkg::CH_SPACE;
        else raw = (p - BASE_LEN < ext_used) ? name_char() : sntdl_pkg::CH_SPACE;
        if ($urandom_range(9) == 0) raw = sntdl_pkg::CH_SPACE;
      end else if (kind <= 6) begin
        raw = ($urandom_range(9) < 6) ? sntdl_pkg::CH_SPACE
                                      : sntdl_pkg::CHAR_W'($urandom_range(255));
      end else if (kind == 7) begin
        raw = (p < lead) ? sntdl_pkg::CH_SPACE : sntdl_pkg::CHAR_W'($urandom_range(255));
      end else begin
        raw = sntdl_pkg::CHAR_W'($urandom_range(255));
      end
      offer_byte(raw, 1'b0, '0);
    end
  endtask

  initial begin
    int stall_left;
    bit stall_done;
    stall_left = 0;
    stall_done = 1'b0;
    char_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        char_ch.ready <= 1'b0;
        stall_left--;
      end else if (!stall_done && bytes_in >= STALL_AT) begin
        stall_done = 1'b1;
        stall_left = STALL_CYCLES - 1;
        char_ch.ready <= 1'b0;
      end else begin
        char_ch.ready <= !(gaps_on && $urandom_range(99) < 12);
      end
    end
  end

  always @(posedge clk) begin : char_check
    char_word_t want;
    if (!rst && char_ch.valid && char_ch.ready) begin
      if (dotted_chars.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected word: char=%h last=%b done=%b",
                   char_ch.out_char, char_ch.run_last, char_ch.name_done);
        mismatches++;
      end else begin
        want = dotted_chars.pop_front();
        if (char_ch.out_char !== want.out_char || char_ch.run_last !== want.run_last ||
            char_ch.name_done !== want.name_done) begin
          if (mismatches < REPORT_MAX)
            $display({"word mismatch: expected char=%h last=%b done=%b, ",
                      "got char=%h last=%b done=%b"},
                     want.out_char, want.run_last, want.name_done,
                     char_ch.out_char, char_ch.run_last, char_ch.name_done);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst               = 1'b1;
    name_ch.valid     = 1'b0;
    name_ch.name_byte = '0;
    name_pos          = '0;
    held_spaces       = '0;
    dot_seen          = 1'b0;
    gaps_on           = 1'b1;
    bytes_in          = 0;
    mismatches        = 0;
    cycles            = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i])
      offer_byte(directed_rows[i].name_byte, directed_rows[i].typed, directed_rows[i].want);
    for (int k = 0; k < RANDOM_NAMES; k++) begin
      gaps_on = !(k >= 12 && k < 22);
      offer_random_name();
    end
    gaps_on = 1'b1;
    name_ch.valid <= 1'b0;
    while (dotted_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && dotted_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
